/* hdl/wagd_pkg.sv */
// ----------------------------------------------------------------------------
// wagd_pkg
// Shared widths, register and action codes, and neighbour offsets for the
// grid diffusion unit.
// ----------------------------------------------------------------------------
package wagd_pkg;

  localparam int GRID_BITS = 6;
  localparam int GRID_SIZE = 1 << GRID_BITS;
  localparam int CELL_AW   = 2 * GRID_BITS;
  localparam int CELLS     = GRID_SIZE * GRID_SIZE;

  localparam int AMT_W  = 24;
  localparam int CELL_W = AMT_W + 1;
  localparam int W_W    = 16;          // weight width
  localparam int USED_W = W_W + 3;     // sum of up to eight weights
  localparam int MC_W   = 35;          // weight times total weight
  localparam int PROD_W = MC_W + AMT_W;
  localparam int NUM_W  = PROD_W - 16;
  localparam int SH_W   = AMT_W + 1;   // share, saturated

  localparam logic [AMT_W-1:0]     AMT_MAX = {AMT_W{1'b1}};
  localparam logic [GRID_BITS-1:0] CENTRE  = GRID_BITS'(GRID_SIZE / 2);

  // configuration register indexes
  localparam logic [2:0] REG_STRAIGHT = 3'd0;
  localparam logic [2:0] REG_CORNER   = 3'd1;
  localparam logic [2:0] REG_PERIOD   = 3'd2;
  localparam logic [2:0] REG_PVALUE   = 3'd3;
  localparam logic [2:0] REG_PRADIUS  = 3'd4;

  // request actions
  localparam logic [1:0] ACT_ADVANCE = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  // neighbour order: row above left to right, left, right, row below
  function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
    case (k)
      3'd0, 3'd3, 3'd5: nb_dx = -2'sd1;
      3'd1, 3'd6:       nb_dx = 2'sd0;
      default:          nb_dx = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: nb_dy = -2'sd1;
      3'd3, 3'd4:       nb_dy = 2'sd0;
      default:          nb_dy = 2'sd1;
    endcase
  endfunction

  function automatic logic nb_straight(input logic [2:0] k);
    case (k)
      3'd1, 3'd3, 3'd4, 3'd6: nb_straight = 1'b1;
      default:                nb_straight = 1'b0;
    endcase
  endfunction

endpackage

/* hdl/wagd_arith.sv */
// ----------------------------------------------------------------------------
// wagd_arith
// Serial share unit: ((mcand * mplier) >> 16) / divisor, saturated to 2^24.
// ----------------------------------------------------------------------------
module wagd_arith
  import wagd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MC_W-1:0]   mcand_i,
  input  logic [AMT_W-1:0]  mplier_i,
  input  logic [USED_W-1:0] divisor_i,
  output logic              done_o,
  output logic [SH_W-1:0]   share_o
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_MUL  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  logic [1:0]        mode_q;
  logic [5:0]        cnt_q;
  logic [PROD_W-1:0] acc_q, mc_q, acc_nx;
  logic [AMT_W-1:0]  mp_q;
  logic [NUM_W-1:0]  num_q, quo_q, quo_nx;
  logic [USED_W:0]   rem_q, rem_sh, rem_nx;
  logic [USED_W-1:0] dv_q;
  logic              done_q;
  logic [SH_W-1:0]   share_q;
  logic              qbit;

  assign acc_nx = mp_q[0] ? acc_q + mc_q : acc_q;
  assign rem_sh = {rem_q[USED_W-1:0], num_q[NUM_W-1]};
  assign qbit   = rem_sh >= {1'b0, dv_q};
  assign rem_nx = qbit ? rem_sh - {1'b0, dv_q} : rem_sh;
  assign quo_nx = {quo_q[NUM_W-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      mc_q    <= '0;
      mp_q    <= '0;
      num_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      dv_q    <= '0;
      done_q  <= 1'b0;
      share_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (mode_q)
        M_IDLE: begin
          if (start_i) begin
            acc_q  <= '0;
            mc_q   <= {{AMT_W{1'b0}}, mcand_i};
            mp_q   <= mplier_i;
            dv_q   <= divisor_i;
            cnt_q  <= '0;
            mode_q <= M_MUL;
          end
        end
        M_MUL: begin
          acc_q <= acc_nx;
          mc_q  <= {mc_q[PROD_W-2:0], 1'b0};
          mp_q  <= {1'b0, mp_q[AMT_W-1:1]};
          if (cnt_q == 6'(AMT_W - 1)) begin
            num_q  <= acc_nx[PROD_W-1:16];
            rem_q  <= '0;
            quo_q  <= '0;
            cnt_q  <= '0;
            mode_q <= M_DIV;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        M_DIV: begin
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          num_q <= {num_q[NUM_W-2:0], 1'b0};
          if (cnt_q == 6'(NUM_W - 1)) begin
            share_q <= (|quo_nx[NUM_W-1:AMT_W]) ? {1'b1, {AMT_W{1'b0}}}
                                                : {1'b0, quo_nx[AMT_W-1:0]};
            done_q  <= 1'b1;
            mode_q  <= M_IDLE;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        default: mode_q <= M_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign share_o = share_q;

endmodule

/* hdl/wall_aware_grid_diffusion_unit.sv */
// ----------------------------------------------------------------------------
// wall_aware_grid_diffusion_unit
// 64 x 64 grid of Q8.16 amounts or walls: write, read or advance a generation.
// ----------------------------------------------------------------------------
// Use: one request channel (action, cell, value, wall mark) and one result
// channel (read value, read wall, generation), each valid/stall. Every request
// gives exactly one result. Registers are written on the plain cfg port; the
// user writes them only while the unit is idle, which the unit does not check.
// Steps: a write passes S_WR, a read S_RD then S_RD_DATA, an unknown action goes
// straight on; each ends in S_RESP, which fills the result register once free.
// An advance reduces the counter one period at a time, stamps the source disc
// on pulse generations, forms the weight products, copies walls into the spare
// bank, then reads each cell in turn; for each non-wall non-empty cell it reads
// its eight neighbours, runs the serial share unit if any is usable and updates
// each usable neighbour. The single read port of each grid bank sets the pace.
// One request is worked at a time; a finished result waits in the output
// register and the next request is taken while it waits.
// Reset: a clearing pass over all 4096 cells zeroes both banks; requests stall
// until it ends. If the receiver stalls, the result holds and a second
// result waits in the unit until the register frees.
// ----------------------------------------------------------------------------
module wall_aware_grid_diffusion_unit
  import wagd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [AMT_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        action_i,
  input  logic [5:0]        cell_x_i,
  input  logic [5:0]        cell_y_i,
  input  logic [AMT_W-1:0]  write_value_i,
  input  logic              write_wall_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [AMT_W-1:0]  read_value_o,
  output logic              read_wall_o,
  output logic [7:0]        generation_o
);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_WR      = 5'd2;
  localparam logic [4:0] S_RD      = 5'd3;
  localparam logic [4:0] S_RD_DATA = 5'd4;
  localparam logic [4:0] S_RESP    = 5'd5;
  localparam logic [4:0] S_MOD     = 5'd6;
  localparam logic [4:0] S_STAMP   = 5'd7;
  localparam logic [4:0] S_WT      = 5'd8;
  localparam logic [4:0] S_INIT    = 5'd9;
  localparam logic [4:0] S_C_RD    = 5'd10;
  localparam logic [4:0] S_C_CHK   = 5'd11;
  localparam logic [4:0] S_NB_RD   = 5'd12;
  localparam logic [4:0] S_NB_CHK  = 5'd13;
  localparam logic [4:0] S_AS_GO   = 5'd14;
  localparam logic [4:0] S_AS_WAIT = 5'd15;
  localparam logic [4:0] S_AC_GO   = 5'd16;
  localparam logic [4:0] S_AC_WAIT = 5'd17;
  localparam logic [4:0] S_RMW_RD  = 5'd18;
  localparam logic [4:0] S_RMW_WR  = 5'd19;
  localparam logic [4:0] S_FIN     = 5'd20;

  // config
  logic [W_W-1:0]   straight_q, corner_q;
  logic [7:0]       period_q;
  logic [AMT_W-1:0] pvalue_q;
  logic [3:0]       pradius_q;

  // control and working registers
  logic [4:0]              state_q, state_d;
  logic [CELL_AW:0]        ctr_q, ctr_d;
  logic [CELL_AW-1:0]      cell_q, cell_d;
  logic [2:0]              k_q, k_d;
  logic [AMT_W-1:0]        amt_q, amt_d;
  logic [7:0]              mask_q, mask_d;
  logic [USED_W-1:0]       used_q, used_d;
  logic [MC_W-1:0]         wts_q, wts_d, wtc_q, wtc_d;
  logic [SH_W-1:0]         shs_q, shs_d, shc_q, shc_d;
  logic [7:0]              gen_q, gen_d;
  logic                    bank_q, bank_d;
  logic signed [4:0]       dx_q, dx_d, dy_q, dy_d;
  logic [AMT_W-1:0]        stamp_q, stamp_d;
  logic                    nbin_q, nbin_d;
  logic [CELL_AW-1:0]      addr_q, addr_d;
  logic [AMT_W-1:0]        wval_q, wval_d;
  logic                    wwall_q, wwall_d;
  logic [AMT_W-1:0]        rval_q, rval_d;
  logic                    rwall_q, rwall_d;
  logic                    ovalid_q, ovalid_d;
  logic [AMT_W-1:0]        oval_q, oval_d;
  logic                    owall_q, owall_d;
  logic [7:0]              ogen_q, ogen_d;

  // grid banks
  logic [CELL_W-1:0] mem0 [CELLS];
  logic [CELL_W-1:0] mem1 [CELLS];
  logic [CELL_W-1:0] m0_rd_q, m1_rd_q;
  logic              m0_we, m1_we;
  logic [CELL_AW-1:0] m0_wa, m1_wa, m0_ra, m1_ra;
  logic [CELL_W-1:0] m0_wd, m1_wd;

  logic               cur_we, nxt_we;
  logic [CELL_AW-1:0] cur_wa, nxt_wa, cur_ra, nxt_ra;
  logic [CELL_W-1:0]  cur_wd, nxt_wd, cur_rd, nxt_rd;

  // derived values
  logic [7:0]           per_eff;
  logic signed [1:0]    dxk, dyk;
  logic [6:0]           nbx, nby;
  logic                 nb_in;
  logic [CELL_AW-1:0]   nb_addr;
  logic                 nb_str;
  logic signed [9:0]    dxe, dye;
  logic [9:0]           dsq, rsq, rr;
  logic signed [4:0]    pos_r, neg_r;
  logic [GRID_BITS-1:0] sx, sy;
  logic [W_W:0]         wsum;
  logic [32:0]          ps_s, ps_c;
  logic [AMT_W+1:0]     rmw_sum;
  logic                 last_cell;

  // share unit
  logic              ar_start, ar_done;
  logic [MC_W-1:0]   ar_mcand;
  logic [SH_W-1:0]   ar_share;

  wagd_arith u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ar_start),
    .mcand_i   (ar_mcand),
    .mplier_i  (amt_q),
    .divisor_i (used_q),
    .done_o    (ar_done),
    .share_o   (ar_share)
  );

  assign per_eff = (period_q == 8'd0) ? 8'd1 : period_q;

  // neighbour address; off-grid shows as bit 6 set (-1 or 64)
  assign dxk     = nb_dx(k_q);
  assign dyk     = nb_dy(k_q);
  assign nbx     = {1'b0, cell_q[GRID_BITS-1:0]} + {{5{dxk[1]}}, dxk};
  assign nby     = {1'b0, cell_q[CELL_AW-1:GRID_BITS]} + {{5{dyk[1]}}, dyk};
  assign nb_in   = !nbx[6] && !nby[6];
  assign nb_addr = {nby[GRID_BITS-1:0], nbx[GRID_BITS-1:0]};
  assign nb_str  = nb_straight(k_q);

  // source disc
  assign dxe   = 10'(dx_q);
  assign dye   = 10'(dy_q);
  assign dsq   = 10'(dxe * dxe + dye * dye);
  assign rr    = {6'd0, pradius_q};
  assign rsq   = 10'(rr * rr);
  assign pos_r = {1'b0, pradius_q};
  assign neg_r = 5'sd0 - pos_r;
  assign sx    = CENTRE + GRID_BITS'(dx_q);
  assign sy    = CENTRE + GRID_BITS'(dy_q);

  // w * T = 4 * w * (straight + corner)
  assign wsum = {1'b0, straight_q} + {1'b0, corner_q};
  assign ps_s = {17'd0, straight_q} * {16'd0, wsum};
  assign ps_c = {17'd0, corner_q} * {16'd0, wsum};

  assign rmw_sum   = {2'b00, nxt_rd[AMT_W-1:0]} + {1'b0, (nb_str ? shs_q : shc_q)};
  assign last_cell = cell_q == CELL_AW'(CELLS - 1);

  assign ar_start = (state_q == S_AS_GO && used_q != '0) || state_q == S_AC_GO;
  assign ar_mcand = (state_q == S_AC_GO) ? wtc_q : wts_q;

  // bank select
  assign cur_rd = bank_q ? m1_rd_q : m0_rd_q;
  assign nxt_rd = bank_q ? m0_rd_q : m1_rd_q;
  assign m0_we  = bank_q ? nxt_we : cur_we;
  assign m0_wa  = bank_q ? nxt_wa : cur_wa;
  assign m0_wd  = bank_q ? nxt_wd : cur_wd;
  assign m0_ra  = bank_q ? nxt_ra : cur_ra;
  assign m1_we  = bank_q ? cur_we : nxt_we;
  assign m1_wa  = bank_q ? cur_wa : nxt_wa;
  assign m1_wd  = bank_q ? cur_wd : nxt_wd;
  assign m1_ra  = bank_q ? cur_ra : nxt_ra;

  always_ff @(posedge clk_i) begin
    if (m0_we) begin
      mem0[m0_wa] <= m0_wd;
    end
    m0_rd_q <= mem0[m0_ra];
  end

  always_ff @(posedge clk_i) begin
    if (m1_we) begin
      mem1[m1_wa] <= m1_wd;
    end
    m1_rd_q <= mem1[m1_ra];
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      straight_q <= 16'd9638;
      corner_q   <= 16'd6746;
      period_q   <= 8'd40;
      pvalue_q   <= 24'd655360;
      pradius_q  <= 4'd4;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STRAIGHT: straight_q <= cfg_data_i[W_W-1:0];
        REG_CORNER:   corner_q   <= cfg_data_i[W_W-1:0];
        REG_PERIOD:   period_q   <= cfg_data_i[7:0];
        REG_PVALUE:   pvalue_q   <= cfg_data_i;
        REG_PRADIUS:  pradius_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    ctr_d    = ctr_q;
    cell_d   = cell_q;
    k_d      = k_q;
    amt_d    = amt_q;
    mask_d   = mask_q;
    used_d   = used_q;
    wts_d    = wts_q;
    wtc_d    = wtc_q;
    shs_d    = shs_q;
    shc_d    = shc_q;
    gen_d    = gen_q;
    bank_d   = bank_q;
    dx_d     = dx_q;
    dy_d     = dy_q;
    stamp_d  = stamp_q;
    nbin_d   = nbin_q;
    addr_d   = addr_q;
    wval_d   = wval_q;
    wwall_d  = wwall_q;
    rval_d   = rval_q;
    rwall_d  = rwall_q;
    ovalid_d = ovalid_q && out_stall_i;
    oval_d   = oval_q;
    owall_d  = owall_q;
    ogen_d   = ogen_q;

    cur_we = 1'b0;
    cur_wa = '0;
    cur_wd = '0;
    cur_ra = '0;
    nxt_we = 1'b0;
    nxt_wa = '0;
    nxt_wd = '0;
    nxt_ra = '0;

    case (state_q)
      S_CLR: begin
        cur_we = 1'b1;
        nxt_we = 1'b1;
        cur_wa = ctr_q[CELL_AW-1:0];
        nxt_wa = ctr_q[CELL_AW-1:0];
        if (ctr_q[CELL_AW-1:0] == CELL_AW'(CELLS - 1)) begin
          ctr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d  = {cell_y_i, cell_x_i};
          wval_d  = write_value_i;
          wwall_d = write_wall_i;
          rval_d  = '0;
          rwall_d = 1'b0;
          case (action_i)
            ACT_ADVANCE: state_d = S_MOD;
            ACT_WRITE:   state_d = S_WR;
            ACT_READ:    state_d = S_RD;
            default:     state_d = S_RESP;
          endcase
        end
      end
      S_WR: begin
        cur_we  = 1'b1;
        cur_wa  = addr_q;
        cur_wd  = wwall_q ? {1'b1, {AMT_W{1'b0}}} : {1'b0, wval_q};
        state_d = S_RESP;
      end
      S_RD: begin
        cur_ra  = addr_q;
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        if (cur_rd[AMT_W]) begin
          rwall_d = 1'b1;
        end else begin
          rval_d = cur_rd[AMT_W-1:0];
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          oval_d   = rval_q;
          owall_d  = rwall_q;
          ogen_d   = gen_q;
          state_d  = S_IDLE;
        end
      end
      S_MOD: begin
        // counter may exceed a freshly written period
        if (gen_q >= per_eff) begin
          gen_d = gen_q - per_eff;
        end else begin
          dx_d = neg_r;
          dy_d = neg_r;
          if (gen_q == 8'd0) begin
            stamp_d = pvalue_q;
            state_d = S_STAMP;
          end else if (gen_q == 8'd2) begin
            stamp_d = '0;
            state_d = S_STAMP;
          end else begin
            state_d = S_WT;
          end
        end
      end
      S_STAMP: begin
        if (dsq <= rsq) begin
          cur_we = 1'b1;
          cur_wa = {sy, sx};
          cur_wd = {1'b0, stamp_q};
        end
        if (dx_q == pos_r) begin
          dx_d = neg_r;
          if (dy_q == pos_r) begin
            state_d = S_WT;
          end else begin
            dy_d = dy_q + 5'sd1;
          end
        end else begin
          dx_d = dx_q + 5'sd1;
        end
      end
      S_WT: begin
        wts_d   = {ps_s, 2'b00};
        wtc_d   = {ps_c, 2'b00};
        ctr_d   = '0;
        state_d = S_INIT;
      end
      S_INIT: begin
        // spare bank takes the wall marks, amounts zero
        if (ctr_q != (CELL_AW + 1)'(CELLS)) begin
          cur_ra = ctr_q[CELL_AW-1:0];
        end
        if (ctr_q != '0) begin
          nxt_we = 1'b1;
          nxt_wa = CELL_AW'(ctr_q - 1'b1);
          nxt_wd = {cur_rd[AMT_W], {AMT_W{1'b0}}};
        end
        if (ctr_q == (CELL_AW + 1)'(CELLS)) begin
          cell_d  = '0;
          state_d = S_C_RD;
        end else begin
          ctr_d = ctr_q + 1'b1;
        end
      end
      S_C_RD: begin
        cur_ra  = cell_q;
        state_d = S_C_CHK;
      end
      S_C_CHK: begin
        if (cur_rd[AMT_W] || cur_rd[AMT_W-1:0] == '0) begin
          if (last_cell) begin
            state_d = S_FIN;
          end else begin
            cell_d  = cell_q + 1'b1;
            state_d = S_C_RD;
          end
        end else begin
          amt_d   = cur_rd[AMT_W-1:0];
          k_d     = '0;
          mask_d  = '0;
          used_d  = '0;
          state_d = S_NB_RD;
        end
      end
      S_NB_RD: begin
        cur_ra  = nb_addr;
        nbin_d  = nb_in;
        state_d = S_NB_CHK;
      end
      S_NB_CHK: begin
        if (nbin_q && !cur_rd[AMT_W]) begin
          mask_d[k_q] = 1'b1;
          used_d = used_q + {3'b000, (nb_str ? straight_q : corner_q)};
        end
        if (k_q == 3'd7) begin
          state_d = S_AS_GO;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_NB_RD;
        end
      end
      S_AS_GO: begin
        // no usable neighbour: amount is dropped
        if (used_q == '0) begin
          if (last_cell) begin
            state_d = S_FIN;
          end else begin
            cell_d  = cell_q + 1'b1;
            state_d = S_C_RD;
          end
        end else begin
          state_d = S_AS_WAIT;
        end
      end
      S_AS_WAIT: begin
        if (ar_done) begin
          shs_d   = ar_share;
          state_d = S_AC_GO;
        end
      end
      S_AC_GO: begin
        state_d = S_AC_WAIT;
      end
      S_AC_WAIT: begin
        if (ar_done) begin
          shc_d   = ar_share;
          k_d     = '0;
          state_d = S_RMW_RD;
        end
      end
      S_RMW_RD: begin
        if (mask_q[k_q]) begin
          nxt_ra  = nb_addr;
          state_d = S_RMW_WR;
        end else if (k_q == 3'd7) begin
          if (last_cell) begin
            state_d = S_FIN;
          end else begin
            cell_d  = cell_q + 1'b1;
            state_d = S_C_RD;
          end
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      S_RMW_WR: begin
        nxt_we = 1'b1;
        nxt_wa = nb_addr;
        nxt_wd = {1'b0, (rmw_sum > {2'b00, AMT_MAX}) ? AMT_MAX : rmw_sum[AMT_W-1:0]};
        if (k_q == 3'd7) begin
          if (last_cell) begin
            state_d = S_FIN;
          end else begin
            cell_d  = cell_q + 1'b1;
            state_d = S_C_RD;
          end
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_RMW_RD;
        end
      end
      S_FIN: begin
        bank_d  = ~bank_q;
        gen_d   = ({1'b0, gen_q} + 9'd1 == {1'b0, per_eff}) ? 8'd0 : gen_q + 8'd1;
        state_d = S_RESP;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      ctr_q    <= '0;
      cell_q   <= '0;
      k_q      <= '0;
      amt_q    <= '0;
      mask_q   <= '0;
      used_q   <= '0;
      wts_q    <= '0;
      wtc_q    <= '0;
      shs_q    <= '0;
      shc_q    <= '0;
      gen_q    <= '0;
      bank_q   <= 1'b0;
      dx_q     <= '0;
      dy_q     <= '0;
      stamp_q  <= '0;
      nbin_q   <= 1'b0;
      addr_q   <= '0;
      wval_q   <= '0;
      wwall_q  <= 1'b0;
      rval_q   <= '0;
      rwall_q  <= 1'b0;
      ovalid_q <= 1'b0;
      oval_q   <= '0;
      owall_q  <= 1'b0;
      ogen_q   <= '0;
    end else begin
      state_q  <= state_d;
      ctr_q    <= ctr_d;
      cell_q   <= cell_d;
      k_q      <= k_d;
      amt_q    <= amt_d;
      mask_q   <= mask_d;
      used_q   <= used_d;
      wts_q    <= wts_d;
      wtc_q    <= wtc_d;
      shs_q    <= shs_d;
      shc_q    <= shc_d;
      gen_q    <= gen_d;
      bank_q   <= bank_d;
      dx_q     <= dx_d;
      dy_q     <= dy_d;
      stamp_q  <= stamp_d;
      nbin_q   <= nbin_d;
      addr_q   <= addr_d;
      wval_q   <= wval_d;
      wwall_q  <= wwall_d;
      rval_q   <= rval_d;
      rwall_q  <= rwall_d;
      ovalid_q <= ovalid_d;
      oval_q   <= oval_d;
      owall_q  <= owall_d;
      ogen_q   <= ogen_d;
    end
  end

  assign in_stall_o   = state_q != S_IDLE;
  assign out_valid_o  = ovalid_q;
  assign read_value_o = oval_q;
  assign read_wall_o  = owall_q;
  assign generation_o = ogen_q;

endmodule
